### rtl/tcl_pkg.sv
`timescale 1ns / 1ps
// Package for the transfer credit limiter: widths, command and outcome codes,
// credit constants. No dependencies.
package tcl_pkg;

  localparam int CountW    = 32;  // transfer counter
  localparam int CreditW   = 12;  // signed credit
  localparam int TimeW     = 32;  // tick clock and stall lengths
  localparam int StallNumW = 16;  // stall count
  localparam int StallSumW = 48;  // summed stall ticks
  localparam int MaxOutW   = 10;  // max_outstanding register
  localparam int CmdW      = 3;
  localparam int OutcomeW  = 3;

  localparam logic [MaxOutW-1:0] MaxOutReset = MaxOutW'(16);

  localparam logic signed [CreditW-1:0] AbortMark     = CreditW'(-999);
  localparam logic signed [CreditW-1:0] ReleaseCredit = CreditW'(4);
  localparam logic signed [CreditW-1:0] CreditMin     = {1'b1, {(CreditW-1){1'b0}}};
  localparam logic [CountW-1:0]         CreditSpan    = CountW'(2 ** (CreditW - 1));

  typedef enum logic [CmdW-1:0] {
    CMD_REQUEST  = 3'd0,
    CMD_RX_POS   = 3'd1,
    CMD_LOAD     = 3'd2,
    CMD_RELEASE  = 3'd3,
    CMD_ABORT    = 3'd4,
    CMD_CLEAR    = 3'd5,
    CMD_TICK     = 3'd6
  } cmd_e;

  typedef enum logic [OutcomeW-1:0] {
    OUT_ACK     = 3'd0,
    OUT_GRANTED = 3'd1,
    OUT_STALLED = 3'd2,
    OUT_ABORTED = 3'd3,
    OUT_REFUSED = 3'd4
  } outcome_e;

endpackage

### rtl/transfer_credit_limiter.sv
`timescale 1ns / 1ps
// Transfer credit limiter top level: input register, one pass of command
// logic, result register. Depends on tcl_pkg.

// One request in, one result out, one request per cycle sustained while the
// result channel does not back-pressure. A request is taken into the input
// register; once the result register is free or draining, the command logic
// updates the credit, counters and stall statistics and loads the result
// register. The rate is set by the single read-modify-write of the state
// registers. The input side keeps accepting while a result waits, until both
// the result register and the input register are full. A transfer request
// takes one unit of credit; credit in -998..0 stalls the sender, -999 is the
// abort mark. Credit saturates to 12 bits. A write on the configuration
// channel sets max_outstanding and reloads the credit without re-evaluating
// a pending stall; write only while idle.
module transfer_credit_limiter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tcl_pkg::MaxOutW-1:0]           max_outstanding_i,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [tcl_pkg::CmdW-1:0]              cmd_i,
  input  logic [tcl_pkg::CountW-1:0]            receiver_position_i,
  input  logic signed [tcl_pkg::CreditW-1:0]    credit_load_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [tcl_pkg::OutcomeW-1:0]          outcome_o,
  output logic signed [tcl_pkg::CreditW-1:0]    credit_now_o,
  output logic [tcl_pkg::CountW-1:0]            transfers_total_o,
  output logic [tcl_pkg::StallNumW-1:0]         stall_total_o,
  output logic [tcl_pkg::TimeW-1:0]             last_stall_ticks_o,
  output logic [tcl_pkg::StallSumW-1:0]         stall_tick_sum_o,
  output logic [tcl_pkg::TimeW-1:0]             stall_tick_max_o,
  output logic [tcl_pkg::TimeW-1:0]             stall_tick_min_o
);
  import tcl_pkg::*;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                       in_valid_q;
  logic [CmdW-1:0]            cmd_q;
  logic [CountW-1:0]          rx_pos_q;
  logic signed [CreditW-1:0]  load_q;
  logic                       out_valid_q;
  logic                       advance;

  // Process the held request when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      rx_pos_q <= receiver_position_i;
      load_q   <= credit_load_i;
    end
  end

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  logic [MaxOutW-1:0]         max_out_q;
  logic signed [CreditW-1:0]  credit_q,      credit_d;
  logic [CountW-1:0]          sent_q,        sent_d;
  logic                       stalled_q,     stalled_d;
  logic                       timed_q,       timed_d;
  logic [TimeW-1:0]           start_q,       start_d;
  logic [TimeW-1:0]           time_q,        time_d;
  logic [StallNumW-1:0]       num_q,         num_d;
  logic [StallSumW-1:0]       sum_q,         sum_d;
  logic [TimeW-1:0]           longest_q,     longest_d;
  logic [TimeW-1:0]           shortest_q,    shortest_d;
  logic [OutcomeW-1:0]        outcome_d;
  logic [TimeW-1:0]           dur_d;

  // ---------------------------------------------------------------------
  // Command logic
  // ---------------------------------------------------------------------
  logic signed [CreditW-1:0]  set_credit;     // credit chosen by cmds 1..4
  logic signed [CreditW-1:0]  req_credit;     // credit after a request
  logic [CountW-1:0]          delta;
  logic [CountW-1:0]          pos_limit;
  logic [TimeW-1:0]           dur_calc;
  logic [StallSumW:0]         sum_wide;
  logic                       set_in_range;
  logic                       req_in_range;

  function automatic logic stall_range(input logic signed [CreditW-1:0] c);
    return (c <= $signed(CreditW'(0))) && (c > AbortMark);
  endfunction

  always_comb begin
    delta     = sent_q - rx_pos_q;
    pos_limit = CountW'(max_out_q) + CreditSpan;
    // Receiver ahead: full window. Else window minus transfers in flight;
    // that difference cannot overflow, only the far end pins at the minimum.
    case (cmd_e'(cmd_q))
      CMD_RX_POS: begin
        if (rx_pos_q > sent_q) begin
          set_credit = CreditW'(max_out_q);
        end else if (delta >= pos_limit) begin
          set_credit = CreditMin;
        end else begin
          set_credit = CreditW'(max_out_q) - delta[CreditW-1:0];
        end
      end
      CMD_LOAD:    set_credit = load_q;
      CMD_RELEASE: set_credit = ReleaseCredit;
      default:     set_credit = AbortMark;
    endcase
    req_credit   = (credit_q == CreditMin) ? CreditMin : credit_q - CreditW'(1);
    set_in_range = stall_range(set_credit);
    req_in_range = stall_range(req_credit);
    dur_calc     = time_q - start_q;
    sum_wide     = {1'b0, sum_q} + (StallSumW + 1)'(dur_calc);
  end

  always_comb begin
    credit_d   = credit_q;
    sent_d     = sent_q;
    stalled_d  = stalled_q;
    timed_d    = timed_q;
    start_d    = start_q;
    time_d     = time_q;
    num_d      = num_q;
    sum_d      = sum_q;
    longest_d  = longest_q;
    shortest_d = shortest_q;
    outcome_d  = OUT_ACK;
    dur_d      = '0;
    unique case (cmd_e'(cmd_q))
      CMD_REQUEST: begin
        if (stalled_q) begin
          outcome_d = OUT_REFUSED;
        end else begin
          credit_d = req_credit;
          sent_d   = sent_q + CountW'(1);
          if (req_in_range) begin
            stalled_d = 1'b1;
            timed_d   = 1'b1;
            start_d   = time_q;
            outcome_d = OUT_STALLED;
          end else begin
            outcome_d = (req_credit == AbortMark) ? OUT_ABORTED : OUT_GRANTED;
          end
        end
      end
      CMD_RX_POS, CMD_LOAD, CMD_RELEASE, CMD_ABORT: begin
        credit_d = set_credit;
        if (stalled_q) begin
          if (set_in_range) begin
            // Stall persists: restart its timer.
            start_d   = time_q;
            timed_d   = 1'b1;
            outcome_d = OUT_STALLED;
          end else begin
            stalled_d = 1'b0;
            timed_d   = 1'b0;
            start_d   = '0;
            outcome_d = (set_credit == AbortMark) ? OUT_ABORTED : OUT_GRANTED;
            if (timed_q) begin
              dur_d = dur_calc;
              if (num_q != '1) num_d = num_q + StallNumW'(1);
              sum_d = sum_wide[StallSumW] ? '1 : sum_wide[StallSumW-1:0];
              if (dur_calc > longest_q)  longest_d  = dur_calc;
              if (dur_calc < shortest_q) shortest_d = dur_calc;
            end
          end
        end
      end
      CMD_CLEAR: begin
        // A pending stall stays but loses its timing.
        timed_d    = 1'b0;
        start_d    = '0;
        num_d      = '0;
        sum_d      = '0;
        longest_d  = '0;
        shortest_d = '1;
        sent_d     = '0;
      end
      CMD_TICK: time_d = time_q + TimeW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_out_q  <= MaxOutReset;
      credit_q   <= CreditW'(MaxOutReset);
      sent_q     <= '0;
      stalled_q  <= 1'b0;
      timed_q    <= 1'b0;
      start_q    <= '0;
      time_q     <= '0;
      num_q      <= '0;
      sum_q      <= '0;
      longest_q  <= '0;
      shortest_q <= '1;
    end else if (cfg_valid_i) begin
      // Configuration write: new window, credit reloaded, stall untouched.
      max_out_q <= max_outstanding_i;
      credit_q  <= CreditW'(max_outstanding_i);
    end else if (advance) begin
      credit_q   <= credit_d;
      sent_q     <= sent_d;
      stalled_q  <= stalled_d;
      timed_q    <= timed_d;
      start_q    <= start_d;
      time_q     <= time_d;
      num_q      <= num_d;
      sum_q      <= sum_d;
      longest_q  <= longest_d;
      shortest_q <= shortest_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      outcome_o          <= outcome_d;
      credit_now_o       <= credit_d;
      transfers_total_o  <= sent_d;
      stall_total_o      <= num_d;
      last_stall_ticks_o <= dur_d;
      stall_tick_sum_o   <= sum_d;
      stall_tick_max_o   <= longest_d;
      stall_tick_min_o   <= shortest_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_timed_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timed_q |-> stalled_q) else $error("stall timer running without a stall");

  a_stall_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (outcome_o == OUT_STALLED || outcome_o == OUT_REFUSED)) |-> stalled_q)
    else $error("stall outcome while not stalled");

  a_duration_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_stall_ticks_o != '0) |-> (stall_total_o != '0))
    else $error("stall length reported but not counted");

  a_min_not_above_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_q != '0) |-> (shortest_q <= longest_q))
    else $error("shortest stall exceeds longest");

  a_empty_input_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o) else $error("empty input register not ready");

endmodule
